@@ design/slip_frame_ring_receiver_defines.svh @@
// assertion macros shared by the slip frame ring receiver modules
`ifndef SLIP_FRAME_RING_RECEIVER_DEFINES_SVH
`define SLIP_FRAME_RING_RECEIVER_DEFINES_SVH
`ifndef SYNTHESIS
`define SFRR_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SFRR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`define SFRR_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define SFRR_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define SFRR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`define SFRR_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

@@ design/sfrr_pkg.sv @@
// shared types and constants of the slip frame ring receiver
package sfrr_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 12;
  localparam int FW_W   = 11;

  // slip special characters
  localparam logic [BYTE_W-1:0] BYTE_FEND  = 8'o300;
  localparam logic [BYTE_W-1:0] BYTE_FESC  = 8'o333;
  localparam logic [BYTE_W-1:0] BYTE_TFEND = 8'o334;
  localparam logic [BYTE_W-1:0] BYTE_TFESC = 8'o335;

  localparam logic CMD_LINE  = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 12'd1280;

  typedef enum logic [3:0] {
    ST_IGNORED      = 4'd0,
    ST_DROPPED      = 4'd1,
    ST_OVERFLOW     = 4'd2,
    ST_STORED       = 4'd3,
    ST_FRAME_STORED = 4'd4,
    ST_NONE_READY   = 4'd5,
    ST_DATA         = 4'd6,
    ST_ESCAPE       = 4'd7,
    ST_FRAME_DONE   = 4'd8,
    ST_TOO_LONG     = 4'd9
  } status_t;

  typedef enum logic {
    BS_IDLE,
    BS_DECODE
  } bstate_t;

  // classified input item
  typedef struct packed {
    logic              cmd;
    logic [BYTE_W-1:0] line_byte;
    logic              is_end;
  } item_t;

  typedef struct packed {
    status_t           status;
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  frame_length;
    logic [FW_W-1:0]   frames_waiting;
  } result_t;

endpackage

@@ design/slip_frame_ring_receiver.sv @@
// top level of the slip frame ring receiver
//
// Line bytes and fetch requests enter through a queue style port: an item
// transfers when push is high and full is low; cmd 0 carries line_byte from
// the serial line, cmd 1 asks for one decoded byte of the oldest frame.
// Every item yields exactly one result, presented while empty is low and
// taken when pop is high. Results come out in item order.
// max_frame_length is written through cfg_valid/cfg_ready (always ready)
// and should only change while the block is idle.
// Timing: each result passes the input queue and result queue registers;
// a fetch result also passes the registered ring ram read. Throughput: one
// line byte per cycle while the result queue has room; a fetch holds off
// new items for its ring read and decode. A two entry queue on each side
// decouples the sides; when the consumer stops popping, results back up
// and full rises after the input queue fills, with nothing lost.
// Reset clears all pointers and counts at once; there is no clearing pass
// and the ring contents are left as they are.
module slip_frame_ring_receiver #(
  parameter int RING_DEPTH = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        cmd,
  input  logic [7:0]  line_byte,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  status,
  output logic [7:0]  data_byte,
  output logic [11:0] frame_length,
  output logic [10:0] frames_waiting,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] max_frame_length
);

  sfrr_pkg::item_t   item;
  sfrr_pkg::result_t result;
  sfrr_pkg::result_t head;
  logic              item_valid;
  logic              take;
  logic              room;
  logic              res_push;

  assign cfg_ready      = 1'b1;
  assign status         = head.status;
  assign data_byte      = head.data_byte;
  assign frame_length   = head.frame_length;
  assign frames_waiting = head.frames_waiting;

  sfrr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .cmd        (cmd),
    .line_byte  (line_byte),
    .item_valid (item_valid),
    .item       (item),
    .take       (take)
  );

  sfrr_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_data   (max_frame_length),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .room       (room),
    .res_push   (res_push),
    .result     (result)
  );

  sfrr_outq u_outq (
    .clk    (clk),
    .rst    (rst),
    .push   (res_push),
    .result (result),
    .room   (room),
    .empty  (empty),
    .pop    (pop),
    .head   (head)
  );

endmodule

@@ design/sfrr_ram.sv @@
// generic single write port ram with registered read
module sfrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/sfrr_front.sv @@
// front end: two entry input queue that classifies line bytes
module sfrr_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  logic           cmd,
  input  logic [7:0]     line_byte,
  output logic           item_valid,
  output sfrr_pkg::item_t item,
  input  logic           take
);

  sfrr_pkg::item_t slots [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            do_push;
  logic            do_pop;

  assign full       = (count == 2'd2);
  assign item_valid = (count != 2'd0);
  assign item       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = take && item_valid;

  // classify and store the incoming item
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr].cmd       <= cmd;
      slots[wr_ptr].line_byte <= line_byte;
      slots[wr_ptr].is_end    <= (line_byte == sfrr_pkg::BYTE_FEND);
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

@@ design/sfrr_outq.sv @@
// two entry result queue towards the consumer
module sfrr_outq (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sfrr_pkg::result_t result,
  output logic             room,
  output logic             empty,
  input  logic             pop,
  output sfrr_pkg::result_t head
);

  sfrr_pkg::result_t slots [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic              do_pop;

  assign room   = (count != 2'd2);
  assign empty  = (count == 2'd0);
  assign head   = slots[rd_ptr];
  assign do_pop = pop && !empty;

  // result storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= result;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, do_pop};
    end
  end

endmodule

@@ design/sfrr_back.sv @@
// back end: ring storage, frame bookkeeping and slip decoding
`include "slip_frame_ring_receiver_defines.svh"
module sfrr_back #(
  parameter int RING_DEPTH = 2048
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [11:0]       cfg_data,
  input  logic              item_valid,
  input  sfrr_pkg::item_t   item,
  output logic              take,
  input  logic              room,
  output logic              res_push,
  output sfrr_pkg::result_t result
);

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int FCW   = (PTR_W > sfrr_pkg::FW_W) ? PTR_W : sfrr_pkg::FW_W;
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(RING_DEPTH - 1);

  sfrr_pkg::bstate_t state, state_next;

  logic [PTR_W-1:0] head_pointer, head_pointer_next;
  logic [PTR_W-1:0] tail_pointer, tail_pointer_next;
  logic [PTR_W-1:0] read_pointer, read_pointer_next;
  logic [FCW-1:0]   frame_count, frame_count_next;
  logic             drop_mode, drop_mode_next;
  logic             inside_frame, inside_frame_next;
  logic             escape_pending, escape_pending_next;
  logic [sfrr_pkg::LEN_W-1:0] decoded_count, decoded_count_next;
  logic [sfrr_pkg::LEN_W-1:0] max_frame_length;

  logic                      ram_we;
  logic                      ram_re;
  logic [sfrr_pkg::BYTE_W-1:0] ram_rdata;
  logic [PTR_W-1:0]          tail_inc;
  logic [PTR_W-1:0]          read_inc;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] ptr);
    wrap_inc = (ptr == LAST_PTR) ? '0 : ptr + PTR_W'(1);
  endfunction

  assign tail_inc = wrap_inc(tail_pointer);
  assign read_inc = wrap_inc(read_pointer);
  assign take     = (state == sfrr_pkg::BS_IDLE) && item_valid && room;

  sfrr_ram #(
    .WIDTH (sfrr_pkg::BYTE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_pointer),
    .wdata (item.line_byte),
    .re    (ram_re),
    .raddr (read_pointer),
    .rdata (ram_rdata)
  );

  // sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      sfrr_pkg::BS_IDLE: begin
        if (take && item.cmd == sfrr_pkg::CMD_FETCH && frame_count != '0) begin
          state_next = sfrr_pkg::BS_DECODE;
        end
      end
      sfrr_pkg::BS_DECODE: state_next = sfrr_pkg::BS_IDLE;
      default:             state_next = sfrr_pkg::BS_IDLE;
    endcase
  end

  // line byte storage, fetch decode and result forming
  always_comb begin
    head_pointer_next   = head_pointer;
    tail_pointer_next   = tail_pointer;
    read_pointer_next   = read_pointer;
    frame_count_next    = frame_count;
    drop_mode_next      = drop_mode;
    inside_frame_next   = inside_frame;
    escape_pending_next = escape_pending;
    decoded_count_next  = decoded_count;
    ram_we              = 1'b0;
    ram_re              = 1'b0;
    res_push            = 1'b0;
    result.status       = sfrr_pkg::ST_IGNORED;
    result.data_byte    = '0;
    result.frame_length = '0;
    case (state)
      sfrr_pkg::BS_IDLE: begin
        if (take) begin
          if (item.cmd == sfrr_pkg::CMD_LINE) begin
            res_push = 1'b1;
            if (drop_mode) begin
              result.status = sfrr_pkg::ST_DROPPED;
              if (item.is_end) begin
                drop_mode_next    = 1'b0;
                inside_frame_next = 1'b0;
              end
            end else if (!inside_frame && item.is_end) begin
              result.status = sfrr_pkg::ST_IGNORED;
            end else if (tail_inc == head_pointer) begin
              drop_mode_next = 1'b1;
              result.status  = sfrr_pkg::ST_OVERFLOW;
            end else begin
              ram_we            = 1'b1;
              tail_pointer_next = tail_inc;
              if (item.is_end) begin
                inside_frame_next = 1'b0;
                frame_count_next  = frame_count + FCW'(1);
                result.status     = sfrr_pkg::ST_FRAME_STORED;
              end else begin
                inside_frame_next = 1'b1;
                result.status     = sfrr_pkg::ST_STORED;
              end
            end
          end else if (frame_count == '0) begin
            res_push      = 1'b1;
            result.status = sfrr_pkg::ST_NONE_READY;
          end else begin
            ram_re = 1'b1;
          end
        end
      end
      sfrr_pkg::BS_DECODE: begin
        res_push          = 1'b1;
        read_pointer_next = read_inc;
        if (ram_rdata == sfrr_pkg::BYTE_FEND) begin
          result.status       = sfrr_pkg::ST_FRAME_DONE;
          result.frame_length = decoded_count;
          head_pointer_next   = read_inc;
          frame_count_next    = frame_count - FCW'(1);
          decoded_count_next  = '0;
          escape_pending_next = 1'b0;
        end else if (decoded_count >= max_frame_length) begin
          // frame too long: flush the whole ring
          result.status       = sfrr_pkg::ST_TOO_LONG;
          head_pointer_next   = '0;
          tail_pointer_next   = '0;
          read_pointer_next   = '0;
          frame_count_next    = '0;
          escape_pending_next = 1'b0;
          decoded_count_next  = '0;
          drop_mode_next      = 1'b1;
        end else if (ram_rdata == sfrr_pkg::BYTE_FESC) begin
          result.status       = sfrr_pkg::ST_ESCAPE;
          escape_pending_next = 1'b1;
        end else begin
          result.status       = sfrr_pkg::ST_DATA;
          escape_pending_next = 1'b0;
          decoded_count_next  = decoded_count + sfrr_pkg::LEN_W'(1);
          if (escape_pending && ram_rdata == sfrr_pkg::BYTE_TFEND) begin
            result.data_byte = sfrr_pkg::BYTE_FEND;
          end else if (escape_pending && ram_rdata == sfrr_pkg::BYTE_TFESC) begin
            result.data_byte = sfrr_pkg::BYTE_FESC;
          end else begin
            result.data_byte = ram_rdata;
          end
        end
      end
      default: ;
    endcase
    result.frames_waiting = frame_count_next[sfrr_pkg::FW_W-1:0];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= sfrr_pkg::BS_IDLE;
      head_pointer     <= '0;
      tail_pointer     <= '0;
      read_pointer     <= '0;
      frame_count      <= '0;
      drop_mode        <= 1'b0;
      inside_frame     <= 1'b0;
      escape_pending   <= 1'b0;
      decoded_count    <= '0;
      max_frame_length <= sfrr_pkg::MAX_LEN_RESET;
    end else begin
      state          <= state_next;
      head_pointer   <= head_pointer_next;
      tail_pointer   <= tail_pointer_next;
      read_pointer   <= read_pointer_next;
      frame_count    <= frame_count_next;
      drop_mode      <= drop_mode_next;
      inside_frame   <= inside_frame_next;
      escape_pending <= escape_pending_next;
      decoded_count  <= decoded_count_next;
      if (cfg_write) begin
        max_frame_length <= cfg_data;
      end
    end
  end

  // checks
  `SFRR_ASSERT_NEXT(a_decode_one_cycle, clk, rst, state == sfrr_pkg::BS_DECODE, state == sfrr_pkg::BS_IDLE, "decode state held longer than one cycle")
  `SFRR_ASSERT_IMPL(a_push_has_room, clk, rst, res_push, room, "result pushed into a full queue")
  `SFRR_ASSERT_NEXT(a_overflow_drops, clk, rst, res_push && result.status == sfrr_pkg::ST_OVERFLOW, drop_mode, "overflow did not enter drop mode")
  `SFRR_ASSERT_NEVER(a_no_write_on_read, clk, rst, ram_we && ram_re, "ring written and read in one cycle")

endmodule
